// ===== hw/rtl/rtia_pkg.sv =====
// Shared constants for the radix tree index allocator.
package rtia_pkg;

   // Default tree geometry.
   localparam int NODE_BYTES_LOG2_DEF    = 5;
   localparam int POINTER_BYTES_LOG2_DEF = 3;
   localparam int NODE_COUNT_DEF         = 256;
   localparam int INDEX_BITS_DEF         = 20;

   // Fixed field widths.
   localparam int DEPTH_W = 4;   // tree depth register
   localparam int ES_W    = 3;   // element_shift register

   // Register file.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_ELEMENT_SHIFT = '0;
   localparam logic [ES_W-1:0] ELEMENT_SHIFT_RESET = 3'd2;

endpackage

// ===== hw/rtl/radix_tree_index_allocator_unit.sv =====
// Radix tree index allocator: maps an element index to a node pool byte address.
//
// Maps req_index to the byte address of its element in a pool of NODE_COUNT nodes
// of 2**NODE_BYTES_LOG2 bytes, arranged as a radix tree that grows on demand.
// After reset the child pointer store (NODE_COUNT * SLOTS entries, 1024 at the
// defaults) is swept to zero, one entry per cycle, with busy high throughout;
// element_shift may be written during that time. An item is taken
// when start is high and busy is low. One shared barrel shifter (index >> bits)
// and a single-port-write, registered-read store do the work under a small
// sequencer: one grow step per new root stacked on top, a fit check, then for
// each tree level on the way down a store read, then a check and fill. The
// result shows on rsp_valid for one cycle, and busy drops in that same cycle.
// The receiver cannot stall the result.
// When the pool runs dry the walk stops at once and the item reports
// rsp_out_of_nodes with a zero address; nodes taken before that are kept.
// element_shift above NODE_BYTES_LOG2-1 is saturated so a leaf holds at least
// two elements.

module radix_tree_index_allocator_unit
   import rtia_pkg::*;
#(
   parameter int NODE_BYTES_LOG2    = NODE_BYTES_LOG2_DEF,
   parameter int POINTER_BYTES_LOG2 = POINTER_BYTES_LOG2_DEF,
   parameter int NODE_COUNT         = NODE_COUNT_DEF,
   parameter int INDEX_BITS         = INDEX_BITS_DEF,
   localparam int NODE_W            = $clog2(NODE_COUNT),
   localparam int ADDR_W            = NODE_W + NODE_BYTES_LOG2
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic [INDEX_BITS-1:0] req_index,
   // result channel
   output logic                  rsp_valid,
   output logic [ADDR_W-1:0]     rsp_byte_address,
   output logic                  rsp_out_of_nodes,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int SLOT_BITS   = NODE_BYTES_LOG2 - POINTER_BYTES_LOG2;
   localparam int SLOTS       = 1 << SLOT_BITS;
   localparam int STORE_DEPTH = NODE_COUNT * SLOTS;
   localparam int STORE_AW    = NODE_W + SLOT_BITS;
   localparam int FREE_W      = $clog2(NODE_COUNT + 1);   // also child entry width
   // bits never exceeds the leaf width plus a full-depth tree
   localparam int BITS_W      =
      $clog2(NODE_BYTES_LOG2 + ((1 << DEPTH_W) + 1) * SLOT_BITS + 1);
   localparam int OFF_W       = NODE_BYTES_LOG2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GROW,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // persistent tree state
   logic [NODE_W-1:0]   root_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [FREE_W-1:0]   next_free_ff;
   logic [ES_W-1:0]     element_shift_ff;
   logic [STORE_AW-1:0] clear_idx_ff;

   // per-item working registers
   logic [INDEX_BITS-1:0] idx_ff;
   logic [ES_W-1:0]       es_ff;
   logic [BITS_W-1:0]     bits_ff;
   logic [NODE_W-1:0]     node_ff;
   logic [DEPTH_W-1:0]    level_ff;
   logic [STORE_AW-1:0]   pos_ff;

   // result registers
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              rsp_oon_ff;

   // child store
   logic [FREE_W-1:0]   store_mem [STORE_DEPTH];
   logic [FREE_W-1:0]   store_rd_ff;
   logic                store_we;
   logic [STORE_AW-1:0] store_wa;
   logic [FREE_W-1:0]   store_wd;
   logic [STORE_AW-1:0] store_ra;

   // combinational helpers
   logic [INDEX_BITS-1:0] shift_out;
   logic [ES_W-1:0]       es_sat;
   logic [BITS_W-1:0]     bits_init;
   logic                  pool_empty;
   logic [NODE_W-1:0]     fresh;
   logic [OFF_W-1:0]      idx_low;
   logic [OFF_W-1:0]      elem_off;
   logic                  csr_write;

   // ---------------------------------------------------------------------------
   // Shared shifter: the upper part of the index above the current bit position.
   // GROW tests it for zero, the walk takes the slot from its low bits.
   assign shift_out = idx_ff >> bits_ff;

   always_comb begin
      if (int'(element_shift_ff) > NODE_BYTES_LOG2 - 1) begin
         es_sat = ES_W'(NODE_BYTES_LOG2 - 1);
      end else begin
         es_sat = element_shift_ff;
      end
   end

   // leaf index bits plus SLOT_BITS per interior level
   assign bits_init = BITS_W'(NODE_BYTES_LOG2) - BITS_W'(es_sat)
                    + BITS_W'(depth_ff) * BITS_W'(SLOT_BITS);

   assign pool_empty = (32'(next_free_ff) >= 32'(NODE_COUNT));
   assign fresh      = next_free_ff[NODE_W-1:0];

   // element offset inside the leaf: low leaf bits of the index, scaled
   assign idx_low  = OFF_W'(idx_ff);
   assign elem_off = idx_low << es_ff;

   assign store_ra = {node_ff, shift_out[SLOT_BITS-1:0]};

   // ---------------------------------------------------------------------------
   // Store write port: clearing sweep, new root link, or filled empty child.
   always_comb begin
      store_we = 1'b0;
      store_wa = pos_ff;
      store_wd = '0;
      case (state_ff)
         ST_CLEAR: begin
            store_we = 1'b1;
            store_wa = clear_idx_ff;
         end
         ST_GROW: begin
            if (shift_out != '0 && !pool_empty) begin
               store_we = 1'b1;
               store_wa = {fresh, SLOT_BITS'(0)};
               store_wd = FREE_W'(root_ff) + FREE_W'(1);
            end
         end
         ST_WALK_CHK: begin
            if (store_rd_ff == '0 && !pool_empty) begin
               store_we = 1'b1;
               store_wa = pos_ff;
               store_wd = next_free_ff + FREE_W'(1);
            end
         end
         default: begin
            store_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wa] <= store_wd;
      end
      store_rd_ff <= store_mem[store_ra];
   end

   // ---------------------------------------------------------------------------
   // Register port
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      if (paddr[CSR_ADDR_W-1:2] == REG_ELEMENT_SHIFT) begin
         prdata = CSR_DATA_W'(element_shift_ff);
      end else begin
         prdata = '0;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clear_idx_ff     <= '0;
         root_ff          <= '0;
         depth_ff         <= '0;
         next_free_ff     <= FREE_W'(1);   // node 0 is the first root
         element_shift_ff <= ELEMENT_SHIFT_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         if (csr_write && paddr[CSR_ADDR_W-1:2] == REG_ELEMENT_SHIFT) begin
            element_shift_ff <= pwdata[ES_W-1:0];
         end

         case (state_ff)
            ST_CLEAR: begin
               clear_idx_ff <= clear_idx_ff + STORE_AW'(1);
               if (32'(clear_idx_ff) == STORE_DEPTH - 1) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (start) begin
                  idx_ff   <= req_index;
                  es_ff    <= es_sat;
                  bits_ff  <= bits_init;
                  state_ff <= ST_GROW;
               end
            end

            // stack new roots until the index fits
            ST_GROW: begin
               if (shift_out != '0) begin
                  if (pool_empty) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_addr_ff  <= '0;
                     rsp_oon_ff   <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     root_ff      <= fresh;
                     depth_ff     <= depth_ff + DEPTH_W'(1);
                     next_free_ff <= next_free_ff + FREE_W'(1);
                     bits_ff      <= bits_ff + BITS_W'(SLOT_BITS);
                  end
               end else begin
                  node_ff  <= root_ff;
                  level_ff <= depth_ff;
                  if (depth_ff == '0) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     bits_ff  <= bits_ff - BITS_W'(SLOT_BITS);
                     state_ff <= ST_WALK_RD;
                  end
               end
            end

            // store read issued this cycle at {node, slot}
            ST_WALK_RD: begin
               pos_ff   <= store_ra;
               state_ff <= ST_WALK_CHK;
            end

            ST_WALK_CHK: begin
               if (store_rd_ff == '0 && pool_empty) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_addr_ff  <= '0;
                  rsp_oon_ff   <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  if (store_rd_ff == '0) begin
                     node_ff      <= fresh;
                     next_free_ff <= next_free_ff + FREE_W'(1);
                  end else begin
                     node_ff <= NODE_W'(store_rd_ff - FREE_W'(1));
                  end
                  level_ff <= level_ff - DEPTH_W'(1);
                  if (level_ff == DEPTH_W'(1)) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     bits_ff  <= bits_ff - BITS_W'(SLOT_BITS);
                     state_ff <= ST_WALK_RD;
                  end
               end
            end

            ST_FINISH: begin
               rsp_valid_ff <= 1'b1;
               rsp_addr_ff  <= {node_ff, elem_off};
               rsp_oon_ff   <= 1'b0;
               state_ff     <= ST_IDLE;
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_address = rsp_addr_ff;
   assign rsp_out_of_nodes = rsp_oon_ff;

   // ---------------------------------------------------------------------------
   // Assertions

   // a result is a single-cycle strobe
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // a failed item reports a zero address
   a_oon_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_nodes) |-> (rsp_byte_address == '0))
      else $error("out_of_nodes result with nonzero address");

   // the bump allocator never runs past the pool
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      32'(next_free_ff) <= NODE_COUNT)
      else $error("next free node beyond pool");

   // a taken item keeps the block busy in the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after taking an item");

   // the tree only deepens by consuming exactly one node
   a_depth_alloc: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && depth_ff != $past(depth_ff))
         |-> (next_free_ff == $past(next_free_ff) + FREE_W'(1)))
      else $error("tree depth changed without a node allocation");

endmodule
